FILE: src/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants
// Pipeline payload type, configuration register indexes and helper functions
// for the barometric pressure compensation core.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int DivBits   = 32;  // quotient bits, one per divider stage
    localparam int StgCnt    = 18;  // datapath stages outside the dividers
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 48;

    localparam logic [31:0] TempOffset = 32'd4000;
    localparam logic [31:0] PressScale = 32'd50000;
    localparam logic [31:0] B4Bias     = 32'd32768;
    localparam logic [31:0] PolyC1     = 32'd3038;
    localparam logic [31:0] PolyC2     = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] PolyC3     = 32'd3791;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_AC_SIGNED   = 3'd0,
        CFG_AC_UNSIGNED = 3'd1,
        CFG_B_WORDS     = 3'd2,
        CFG_M_WORDS     = 3'd3,
        CFG_OSS         = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] ut;
        logic [31:0] up;
        logic [31:0] x1;
        logic [31:0] tt;
        logic [31:0] b6;
        logic [31:0] sq;
        logic [31:0] ac2b6;
        logic [31:0] ac3b6;
        logic [31:0] b2sq;
        logic [31:0] b1sq;
        logic [31:0] x3;
        logic [31:0] x3c;
        logic [31:0] b3;
        logic [31:0] b4;
        logic [31:0] b7;
        logic [31:0] p;
        logic [31:0] pm1;
        logic [31:0] pm2;
        logic [31:0] num;
        logic [31:0] den;
        logic        err_t;
        logic        err_p;
        logic        neg;
        logic        post;
    } t_pipe;

    // 16-bit signed word, sign extended
    function automatic logic [31:0] sx16(input logic [15:0] w);
        sx16 = {{16{w[15]}}, w};
    endfunction

    // arithmetic right shift on a 32-bit two's complement word
    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
        asr = 32'($signed(v) >>> s);
    endfunction

endpackage

FILE: src/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div: pipelined unsigned divider
// 32/32 restoring division, one quotient bit per stage, payload rides along.
// ----------------------------------------------------------------------------
module bpc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  bpc_pkg::t_pipe    i_side,
    input  logic [31:0]       i_num,
    input  logic [31:0]       i_den,
    output logic              o_valid,
    output bpc_pkg::t_pipe    o_side,
    output logic [31:0]       o_quo
);

    logic [31:0]    r_rem [bpc_pkg::DivBits];
    logic [31:0]    r_quo [bpc_pkg::DivBits];
    logic [31:0]    r_den [bpc_pkg::DivBits];
    bpc_pkg::t_pipe r_sd  [bpc_pkg::DivBits];
    logic           r_vd  [bpc_pkg::DivBits];

    for (genvar g = 0; g < bpc_pkg::DivBits; g++) begin : g_stg
        logic [31:0]    pr, pq, pd;
        bpc_pkg::t_pipe ps;
        logic           pv;
        logic [32:0]    trial, diff;
        logic [31:0]    n_rem, n_quo;

        if (g == 0) begin : g_first
            assign pr = '0;
            assign pq = i_num;
            assign pd = i_den;
            assign ps = i_side;
            assign pv = i_valid;
        end else begin : g_next
            assign pr = r_rem[g-1];
            assign pq = r_quo[g-1];
            assign pd = r_den[g-1];
            assign ps = r_sd[g-1];
            assign pv = r_vd[g-1];
        end

        always_comb begin
            trial = {pr, pq[31]};
            diff  = trial - {1'b0, pd};
            if (!diff[32]) begin
                n_rem = diff[31:0];
                n_quo = {pq[30:0], 1'b1};
            end else begin
                n_rem = trial[31:0];
                n_quo = {pq[30:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[g] <= 1'b0;
            end else if (i_en) begin
                r_vd[g] <= pv;
            end
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_quo[g] <= n_quo;
                r_den[g] <= pd;
                r_sd[g]  <= ps;
            end
        end
    end

    assign o_valid = r_vd[bpc_pkg::DivBits-1];
    assign o_side  = r_sd[bpc_pkg::DivBits-1];
    assign o_quo   = r_quo[bpc_pkg::DivBits-1];

endmodule

FILE: src/barometric_pressure_compensation_core.sv
// ----------------------------------------------------------------------------
// barometric_pressure_compensation_core
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one beat per reading: the
//   raw temperature word and the three raw pressure bytes. Output channel
//   (o_out_valid / i_out_stall) returns one beat per reading: temperature in
//   0.1 C, pressure in Pa, and a divide error flag. A zero temperature
//   divisor zeroes both results; a zero B4 zeroes only the pressure.
//   Calibration and oversampling must be loaded through the write port
//   (i_cfg_wr_en, i_cfg_index, i_cfg_wr_data) only while the core is idle;
//   the core does not enforce this. Data passes 18 datapath stages and two
//   32-stage dividers, one quotient bit per stage, one beat per cycle while
//   not stalled. A stalled valid result freezes the whole pipeline and
//   raises o_in_stall in the same cycle; nothing is dropped or repeated.
//   Synchronous reset clears all valid bits and the calibration registers.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [15:0]                     i_raw_temperature,
    input  logic [23:0]                     i_raw_pressure_bytes,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [31:0]              o_temperature_tenths,
    output logic signed [31:0]              o_pressure_pa,
    output logic                            o_divide_error,
    input  logic                            i_cfg_wr_en,
    input  logic [bpc_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [bpc_pkg::CfgDataW-1:0]    i_cfg_wr_data
);

    // calibration registers
    logic [47:0] r_cal_acs, r_cal_acu;
    logic [31:0] r_cal_b, r_cal_m;
    logic [1:0]  r_oss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_acs <= '0;
            r_cal_acu <= '0;
            r_cal_b   <= '0;
            r_cal_m   <= '0;
            r_oss     <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (bpc_pkg::t_cfg_idx'(i_cfg_index))
                bpc_pkg::CFG_AC_SIGNED:   r_cal_acs <= i_cfg_wr_data;
                bpc_pkg::CFG_AC_UNSIGNED: r_cal_acu <= i_cfg_wr_data;
                bpc_pkg::CFG_B_WORDS:     r_cal_b   <= i_cfg_wr_data[31:0];
                bpc_pkg::CFG_M_WORDS:     r_cal_m   <= i_cfg_wr_data[31:0];
                bpc_pkg::CFG_OSS:         r_oss     <= i_cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = bpc_pkg::sx16(r_cal_acs[47:32]);
    assign ac2 = bpc_pkg::sx16(r_cal_acs[31:16]);
    assign ac3 = bpc_pkg::sx16(r_cal_acs[15:0]);
    assign ac4 = {16'b0, r_cal_acu[47:32]};
    assign ac5 = {16'b0, r_cal_acu[31:16]};
    assign ac6 = {16'b0, r_cal_acu[15:0]};
    assign b1  = bpc_pkg::sx16(r_cal_b[31:16]);
    assign b2  = bpc_pkg::sx16(r_cal_b[15:0]);
    assign mc  = bpc_pkg::sx16(r_cal_m[31:16]);
    assign md  = bpc_pkg::sx16(r_cal_m[15:0]);

    // global advance: freeze only when a finished beat is held
    logic en;
    assign en         = !(o_out_valid && i_out_stall);
    assign o_in_stall = !en;

    bpc_pkg::t_pipe r_s [bpc_pkg::StgCnt];
    logic           r_v [bpc_pkg::StgCnt];
    bpc_pkg::t_pipe n_s [bpc_pkg::StgCnt];
    logic           n_v [bpc_pkg::StgCnt];

    logic           d1_valid, d2_valid;
    bpc_pkg::t_pipe d1_side, d2_side;
    logic [31:0]    d1_quo, d2_quo;

    bpc_div u_div_temp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v[3]),
        .i_side  (r_s[3]),
        .i_num   (r_s[3].num),
        .i_den   (r_s[3].den),
        .o_valid (d1_valid),
        .o_side  (d1_side),
        .o_quo   (d1_quo)
    );

    bpc_div u_div_press (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v[12]),
        .i_side  (r_s[12]),
        .i_num   (r_s[12].num),
        .i_den   (r_s[12].b4),
        .o_valid (d2_valid),
        .o_side  (d2_side),
        .o_quo   (d2_quo)
    );

    always_comb begin
        logic [31:0] den, num, q, b5, v;
        for (int k = 1; k < bpc_pkg::StgCnt; k++) begin
            n_s[k] = r_s[k-1];
            n_v[k] = r_v[k-1];
        end

        // 0: capture, align pressure word to oversampling
        n_s[0]    = r_s[0];
        n_v[0]    = i_in_valid;
        n_s[0].ut = i_raw_temperature;
        n_s[0].up = {8'b0, i_raw_pressure_bytes} >> (4'd8 - {2'b0, r_oss});

        // 1: UT - AC6
        n_s[1].x1 = {16'b0, r_s[0].ut} - ac6;
        // 2: X1 = (UT - AC6) * AC5 >> 15
        n_s[2].x1 = bpc_pkg::asr(32'(r_s[1].x1 * ac5), 5'd15);
        // 3: divider operands as magnitudes
        den = r_s[2].x1 + md;
        num = mc << 11;
        n_s[3].err_t = (den == '0);
        n_s[3].neg   = num[31] ^ den[31];
        n_s[3].num   = num[31] ? -num : num;
        n_s[3].den   = den[31] ? -den : den;

        // 4: B5, temperature, B6
        n_s[4] = d1_side;
        n_v[4] = d1_valid;
        q      = d1_side.neg ? -d1_quo : d1_quo;
        b5     = d1_side.x1 + q;
        n_s[4].tt = bpc_pkg::asr(b5 + 32'd8, 5'd4);
        n_s[4].b6 = b5 - bpc_pkg::TempOffset;

        // 5: products on B6
        n_s[5].sq    = 32'(r_s[4].b6 * r_s[4].b6);
        n_s[5].ac2b6 = 32'(ac2 * r_s[4].b6);
        n_s[5].ac3b6 = 32'(ac3 * r_s[4].b6);
        // 6: scale
        n_s[6].sq    = bpc_pkg::asr(r_s[5].sq, 5'd12);
        n_s[6].ac2b6 = bpc_pkg::asr(r_s[5].ac2b6, 5'd11);
        n_s[6].ac3b6 = bpc_pkg::asr(r_s[5].ac3b6, 5'd13);
        // 7: products on the square term
        n_s[7].b2sq = 32'(b2 * r_s[6].sq);
        n_s[7].b1sq = 32'(b1 * r_s[6].sq);
        // 8: X3 for B3 and for B4
        n_s[8].x3  = bpc_pkg::asr(r_s[7].b2sq, 5'd11) + r_s[7].ac2b6;
        n_s[8].x3c = bpc_pkg::asr(r_s[7].ac3b6 + bpc_pkg::asr(r_s[7].b1sq, 5'd16)
                                  + 32'd2, 5'd2);
        // 9: B3 (divide by four toward zero), B4 product
        v = (((ac1 << 2) + r_s[8].x3) << r_oss) + 32'd2;
        n_s[9].b3 = bpc_pkg::asr(v + (v[31] ? 32'd3 : 32'd0), 5'd2);
        n_s[9].b4 = 32'(ac4 * (r_s[8].x3c + bpc_pkg::B4Bias));
        // 10: B4, UP - B3
        n_s[10].b4    = r_s[9].b4 >> 15;
        n_s[10].err_p = ((r_s[9].b4 >> 15) == '0);
        n_s[10].b7    = r_s[9].up - r_s[9].b3;
        // 11: B7
        n_s[11].b7 = 32'(r_s[10].b7 * (bpc_pkg::PressScale >> r_oss));
        // 12: doubling before or after the divide
        n_s[12].post = r_s[11].b7[31];
        n_s[12].num  = r_s[11].b7[31] ? r_s[11].b7 : (r_s[11].b7 << 1);

        // 13: raw pressure
        n_s[13]   = d2_side;
        n_v[13]   = d2_valid;
        n_s[13].p = d2_side.post ? (d2_quo << 1) : d2_quo;
        // 14: correction products
        n_s[14].pm1 = 32'(bpc_pkg::asr(r_s[13].p, 5'd8) * bpc_pkg::asr(r_s[13].p, 5'd8));
        n_s[14].pm2 = 32'(bpc_pkg::PolyC2 * r_s[13].p);
        // 15
        n_s[15].pm1 = 32'(r_s[14].pm1 * bpc_pkg::PolyC1);
        // 16
        n_s[16].x3 = bpc_pkg::asr(r_s[15].pm1, 5'd16) + bpc_pkg::asr(r_s[15].pm2, 5'd16)
                     + bpc_pkg::PolyC3;
        // 17: final pressure
        n_s[17].p = r_s[16].p + bpc_pkg::asr(r_s[16].x3, 5'd4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < bpc_pkg::StgCnt; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (en) begin
            for (int k = 0; k < bpc_pkg::StgCnt; k++) begin
                r_v[k] <= n_v[k];
            end
        end
        if (en) begin
            for (int k = 0; k < bpc_pkg::StgCnt; k++) begin
                r_s[k] <= n_s[k];
            end
        end
    end

    assign o_out_valid          = r_v[bpc_pkg::StgCnt-1];
    assign o_temperature_tenths = r_s[bpc_pkg::StgCnt-1].err_t ? '0
                                  : r_s[bpc_pkg::StgCnt-1].tt;
    assign o_pressure_pa        = (r_s[bpc_pkg::StgCnt-1].err_t
                                   || r_s[bpc_pkg::StgCnt-1].err_p) ? '0
                                  : r_s[bpc_pkg::StgCnt-1].p;
    assign o_divide_error       = r_s[bpc_pkg::StgCnt-1].err_t
                                  || r_s[bpc_pkg::StgCnt-1].err_p;

    // the input side stalls only behind a held result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    // a divide error always clears the pressure
    a_err_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_divide_error) |-> (o_pressure_pa == '0))
        else $error("pressure not cleared on divide error");

    // a frozen pipeline keeps the held result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_pressure_pa)))
        else $error("held result changed");

endmodule
